/* hdl/sfd_pkg.sv */
// Shared types and constants for the spring force pipeline.
package sfd_pkg;

    localparam int CoordW  = 32;
    localparam int DiffW   = CoordW + 1;
    localparam int SumW    = 68;
    localparam int LenW    = 34;
    localparam int StW     = LenW + 1;
    localparam int KW      = 16;
    localparam int ProdW   = KW + StW;
    localparam int NumW    = ProdW + DiffW;
    localparam int DenW    = LenW + 8;
    localparam int QW      = 32;
    localparam int SqCells = LenW;
    localparam int DvCells = QW;
    localparam int Axes    = 3;

    localparam logic REG_SPRING_CONSTANT = 1'b0;
    localparam logic REG_REST_LENGTH     = 1'b1;

    typedef struct packed {
        logic [Axes-1:0][DiffW-1:0] dm;
        logic [Axes-1:0]            dneg;
    } t_side;

    typedef struct packed {
        logic [SumW-1:0] rem;
        logic [SumW-1:0] res;
        logic [SumW-1:0] one;
        t_side           side;
    } t_sq;

    typedef struct packed {
        logic [Axes-1:0][DenW-1:0] rem;
        logic [Axes-1:0][QW-1:0]   low;
        logic [Axes-1:0][QW-1:0]   q;
        logic [DenW-1:0]           den;
        logic [Axes-1:0]           ovf;
        logic [Axes-1:0]           neg;
        logic                      zero;
        logic [LenW-1:0]           len;
        logic [StW-1:0]            st;
    } t_dv;

endpackage

/* hdl/sfd_sqrt_cell.sv */
// One bit step of the integer square root chain.
module sfd_sqrt_cell import sfd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_v,
    input  t_sq  i_cell,
    output logic o_v,
    output t_sq  o_cell
);

    logic        r_v;
    t_sq         r_cell;
    t_sq         n_cell;
    logic [SumW:0] trial;

    always_comb begin
        n_cell = i_cell;
        trial  = {1'b0, i_cell.res} + {1'b0, i_cell.one};
        if ({1'b0, i_cell.rem} >= trial) begin
            n_cell.rem = i_cell.rem - trial[SumW-1:0];
            n_cell.res = (i_cell.res >> 1) + i_cell.one;
        end else begin
            n_cell.res = i_cell.res >> 1;
        end
        n_cell.one = i_cell.one >> 2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_v    = r_v;
    assign o_cell = r_cell;

endmodule

/* hdl/sfd_div_cell.sv */
// One quotient bit step of the three-lane restoring divider chain.
module sfd_div_cell import sfd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_v,
    input  t_dv  i_cell,
    output logic o_v,
    output t_dv  o_cell
);

    logic          r_v;
    t_dv           r_cell;
    t_dv           n_cell;
    logic [DenW:0] rem2 [Axes];

    always_comb begin
        n_cell = i_cell;
        for (int a = 0; a < Axes; a++) begin
            rem2[a] = {i_cell.rem[a], i_cell.low[a][QW-1]};
            n_cell.low[a] = {i_cell.low[a][QW-2:0], 1'b0};
            if (rem2[a] >= {1'b0, i_cell.den}) begin
                n_cell.rem[a] = DenW'(rem2[a] - {1'b0, i_cell.den});
                n_cell.q[a]   = {i_cell.q[a][QW-2:0], 1'b1};
            end else begin
                n_cell.rem[a] = rem2[a][DenW-1:0];
                n_cell.q[a]   = {i_cell.q[a][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_v    = r_v;
    assign o_cell = r_cell;

endmodule

/* hdl/spring_force_3d.sv */
// Top level of the Hooke spring force pipeline.
//
//  channel   dir  handshake                        payload
//  -------   ---  -------------------------------  -------------------------------
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  start x,y,z then end x,y,z
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  force x,y,z, length, stretch; sat
//  cfg       in   i_cfg_wr_en                      k (index 0), rest length (index 1)
//
// One word is accepted per cycle while ready is high; each result passes through:
// three front stages, 34 root cells, four product stages, 32 divider cells and
// the output register. Reset clears only valid flags and the two registers.
// A skid register behind the output lets the pipe run one word past a stall;
// while it is full the whole pipe holds and input ready drops.
module spring_force_3d import sfd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z (32 bits each)
    input  logic [191:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // force_x, force_y, force_z (32), spring_length (34), stretch (35), 3 pad zeros
    output logic [167:0] o_m_axis_tdata,
    // saturated
    output logic [0:0]   o_m_axis_tuser,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_addr,
    input  logic [33:0]  i_cfg_wdata
);

    // configuration registers
    logic [KW-1:0]   r_k;
    logic [LenW-1:0] r_rest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_rest <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_SPRING_CONSTANT: r_k    <= i_cfg_wdata[KW-1:0];
                REG_REST_LENGTH:     r_rest <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    logic r_skid_v;
    assign en = !r_skid_v;
    assign o_s_axis_tready = en;

    // stage 1: per-axis differences
    logic                          r1_v;
    logic signed [Axes-1:0][DiffW-1:0] r1_d;
    logic signed [Axes-1:0][DiffW-1:0] n1_d;

    always_comb begin
        for (int a = 0; a < Axes; a++) begin
            n1_d[a] = $signed({i_s_axis_tdata[(a+3)*CoordW+CoordW-1],
                               i_s_axis_tdata[(a+3)*CoordW +: CoordW]})
                    - $signed({i_s_axis_tdata[a*CoordW+CoordW-1],
                               i_s_axis_tdata[a*CoordW +: CoordW]});
        end
    end

    // stage 2: magnitudes and squares
    logic                        r2_v;
    t_side                       r2_side;
    logic [Axes-1:0][2*DiffW-1:0] r2_sq;
    t_side                       n2_side;

    always_comb begin
        for (int a = 0; a < Axes; a++) begin
            n2_side.dneg[a] = r1_d[a][DiffW-1];
            n2_side.dm[a]   = r1_d[a][DiffW-1] ? DiffW'(-r1_d[a]) : DiffW'(r1_d[a]);
        end
    end

    // stage 3: sum of squares
    logic  r3_v;
    t_sq   r3_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_axis_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d    <= n1_d;
            r2_side <= n2_side;
            for (int a = 0; a < Axes; a++) begin
                r2_sq[a] <= n2_side.dm[a] * n2_side.dm[a];
            end
            r3_sq.rem  <= SumW'(r2_sq[0]) + SumW'(r2_sq[1]) + SumW'(r2_sq[2]);
            r3_sq.res  <= '0;
            r3_sq.one  <= SumW'(1) << (2 * (LenW - 1));
            r3_sq.side <= r2_side;
        end
    end

    // square root chain, one result bit per cell
    logic sq_v [SqCells+1];
    t_sq  sq_c [SqCells+1];
    assign sq_v[0] = r3_v;
    assign sq_c[0] = r3_sq;

    for (genvar g = 0; g < SqCells; g++) begin : g_sq
        sfd_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_v    (sq_v[g]),
            .i_cell (sq_c[g]),
            .o_v    (sq_v[g+1]),
            .o_cell (sq_c[g+1])
        );
    end

    // stage L: stretch, its magnitude times k, force signs
    logic            n_l_len;
    logic [LenW-1:0] l_len;
    logic [StW-1:0]  l_st;
    logic [StW-1:0]  l_smag;
    assign l_len  = sq_c[SqCells].res[LenW-1:0];
    assign l_st   = {1'b0, l_len} - {1'b0, r_rest};
    assign l_smag = l_st[StW-1] ? StW'(-l_st) : l_st;
    assign n_l_len = 1'b0;

    logic                    rl_v, rm1_v, rm2_v, rd_v;
    logic [LenW-1:0]         rl_len, rm1_len, rm2_len;
    logic [StW-1:0]          rl_st, rm1_st, rm2_st;
    logic [ProdW-1:0]        rl_p;
    logic [Axes-1:0]         rl_neg, rm1_neg, rm2_neg;
    logic [Axes-1:0][DiffW-1:0] rl_dm;
    logic [Axes-1:0][25+DiffW:0] rm1_lo;
    logic [Axes-1:0][24+DiffW:0] rm1_hi;
    logic [Axes-1:0][NumW-1:0] rm2_num;
    t_dv                     rd_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rl_v  <= 1'b0;
            rm1_v <= 1'b0;
            rm2_v <= 1'b0;
            rd_v  <= 1'b0;
        end else if (en) begin
            rl_v  <= sq_v[SqCells];
            rm1_v <= rl_v;
            rm2_v <= rm1_v;
            rd_v  <= rm2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rl_len <= l_len | LenW'(n_l_len);
            rl_st  <= l_st;
            rl_p   <= ProdW'(r_k) * ProdW'(l_smag);
            rl_dm  <= sq_c[SqCells].side.dm;
            for (int a = 0; a < Axes; a++) begin
                rl_neg[a] <= (l_st[StW-1] == sq_c[SqCells].side.dneg[a]);
            end
            // split the wide product into two partials per axis
            rm1_len <= rl_len;
            rm1_st  <= rl_st;
            rm1_neg <= rl_neg;
            for (int a = 0; a < Axes; a++) begin
                rm1_lo[a] <= rl_p[25:0] * rl_dm[a];
                rm1_hi[a] <= rl_p[ProdW-1:26] * rl_dm[a];
            end
            rm2_len <= rm1_len;
            rm2_st  <= rm1_st;
            rm2_neg <= rm1_neg;
            for (int a = 0; a < Axes; a++) begin
                rm2_num[a] <= NumW'(rm1_lo[a]) + {rm1_hi[a], 26'b0};
            end
            // divider entry: catch quotients of 2^32 and above up front
            rd_c.den  <= {rm2_len, 8'b0};
            rd_c.zero <= (rm2_len == '0);
            rd_c.len  <= rm2_len;
            rd_c.st   <= rm2_st;
            rd_c.neg  <= rm2_neg;
            for (int a = 0; a < Axes; a++) begin
                rd_c.ovf[a] <= rm2_num[a][NumW-1:QW] >= (NumW-QW)'({rm2_len, 8'b0});
                rd_c.rem[a] <= rm2_num[a][QW+DenW-1:QW];
                rd_c.low[a] <= rm2_num[a][QW-1:0];
                rd_c.q[a]   <= '0;
            end
        end
    end

    // divider chain, one quotient bit per cell
    logic dv_v [DvCells+1];
    t_dv  dv_c [DvCells+1];
    assign dv_v[0] = rd_v;
    assign dv_c[0] = rd_c;

    for (genvar g = 0; g < DvCells; g++) begin : g_dv
        sfd_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_v    (dv_v[g]),
            .i_cell (dv_c[g]),
            .o_v    (dv_v[g+1]),
            .o_cell (dv_c[g+1])
        );
    end

    // final stage: saturate and apply sign
    t_dv                     fin;
    logic [Axes-1:0][QW-1:0] f_force;
    logic [Axes-1:0]         f_sat;
    logic [QW-1:0]           lim [Axes];
    logic [QW-1:0]           mag [Axes];
    assign fin = dv_c[DvCells];

    always_comb begin
        for (int a = 0; a < Axes; a++) begin
            lim[a]   = fin.neg[a] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            f_sat[a] = 1'b0;
            mag[a]   = fin.q[a];
            if (fin.zero) begin
                mag[a] = '0;
            end else if (fin.ovf[a] || fin.q[a] > lim[a]) begin
                mag[a]   = lim[a];
                f_sat[a] = 1'b1;
            end
            f_force[a] = fin.neg[a] ? QW'(-mag[a]) : mag[a];
        end
    end

    logic [167:0] p_data;
    assign p_data = {3'b000, fin.st, fin.len, f_force[2], f_force[1], f_force[0]};

    // output register with skid
    logic         r_o_v, r_o_sat, r_skid_sat;
    logic [167:0] r_o_data, r_skid_data;
    logic         take;
    assign take = r_o_v && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v    <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_skid_v <= 1'b0;
            end
        end else if (dv_v[DvCells]) begin
            if (!r_o_v || take) begin
                r_o_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_o_data <= r_skid_data;
                r_o_sat  <= r_skid_sat;
            end
        end else if (dv_v[DvCells]) begin
            if (!r_o_v || take) begin
                r_o_data <= p_data;
                r_o_sat  <= |f_sat;
            end else begin
                r_skid_data <= p_data;
                r_skid_sat  <= |f_sat;
            end
        end
    end

    assign o_m_axis_tvalid   = r_o_v;
    assign o_m_axis_tdata    = r_o_data;
    assign o_m_axis_tuser[0] = r_o_sat;

endmodule
